[sv/sld_pkg.sv]
// Shared types and constants for the sync/length/XOR frame deframer.
// No dependencies; imported by every module of the block.
package sld_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_END_MARKER  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MSB_FIRST   = 3'd4;

    // Register reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hE1;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h1E;
    localparam logic [7:0]  END_MARKER_RST  = 8'hEF;
    localparam logic [15:0] MIN_LENGTH_RST  = 16'd10;
    localparam logic        MSB_FIRST_RST   = 1'b1;

    // Framing constants
    localparam logic [15:0] HARD_MIN_LENGTH = 16'd10;
    localparam logic [15:0] HEADER_BYTES    = 16'd4;
    localparam logic [16:0] XOR_START       = 17'd4;

    // Frame status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN0 = 2'd1,
        PH_LEN1 = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  end_marker;
        logic [15:0] min_frame_length;
        logic        length_msb_first;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic [15:0] body_index;
        logic        frame_last;
        logic [1:0]  frame_status;
    } t_result;

endpackage

[sv/sld_cfg_regs.sv]
// Configuration register bank of the frame deframer.
// Depends on sld_pkg.
module sld_cfg_regs
    import sld_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  n_cfg.sync_first       = i_cfg_data[7:0];
                CFG_SYNC_SECOND: n_cfg.sync_second      = i_cfg_data[7:0];
                CFG_END_MARKER:  n_cfg.end_marker       = i_cfg_data[7:0];
                CFG_MIN_LENGTH:  n_cfg.min_frame_length = i_cfg_data;
                CFG_MSB_FIRST:   n_cfg.length_msb_first = i_cfg_data[0];
                default:         n_cfg = r_cfg;  // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first       <= SYNC_FIRST_RST;
            r_cfg.sync_second      <= SYNC_SECOND_RST;
            r_cfg.end_marker       <= END_MARKER_RST;
            r_cfg.min_frame_length <= MIN_LENGTH_RST;
            r_cfg.length_msb_first <= MSB_FIRST_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/sld_core.sv]
// Framing state machine: sync hunt, length capture, body pass-through and checks.
// Depends on sld_pkg.
module sld_core
    import sld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic        r_sync_armed, n_sync_armed;
    logic [7:0]  r_len_first, n_len_first;
    logic [15:0] r_body_length, n_body_length;
    logic [15:0] r_byte_position, n_byte_position;
    logic [7:0]  r_running_xor, n_running_xor;
    logic        r_checksum_matched, n_checksum_matched;

    logic [15:0] frame_len;
    logic [15:0] min_len;
    logic        len_short;
    logic        sync_hit;
    logic [16:0] pos_x;
    logic [16:0] len_x;
    logic        xor_en;
    logic        sum_point;
    logic        body_last;
    logic        matched_now;

    // Shared decode
    always_comb begin
        frame_len = i_cfg.length_msb_first ? {r_len_first, i_rx_byte}
                                           : {i_rx_byte, r_len_first};
        min_len   = (i_cfg.min_frame_length < HARD_MIN_LENGTH) ? HARD_MIN_LENGTH
                                                               : i_cfg.min_frame_length;
        len_short = frame_len < min_len;
        sync_hit  = r_sync_armed && (i_rx_byte == i_cfg.sync_second);
        pos_x     = {1'b0, r_byte_position};
        len_x     = {1'b0, r_body_length};
        xor_en    = (pos_x >= XOR_START) && ((pos_x + 17'd3) <= len_x);
        sum_point = (pos_x + 17'd2) == len_x;
        body_last = (pos_x + 17'd1) >= len_x;
        matched_now = sum_point ? (r_running_xor == i_rx_byte) : r_checksum_matched;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: if (sync_hit) n_phase = PH_LEN0;
                PH_LEN0: n_phase = PH_LEN1;
                PH_LEN1: n_phase = len_short ? PH_HUNT : PH_BODY;
                PH_BODY: if (body_last) n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        n_sync_armed       = r_sync_armed;
        n_len_first        = r_len_first;
        n_body_length      = r_body_length;
        n_byte_position    = r_byte_position;
        n_running_xor      = r_running_xor;
        n_checksum_matched = r_checksum_matched;
        o_res_valid        = 1'b0;
        o_res              = '0;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    n_sync_armed = sync_hit ? 1'b0 : (i_rx_byte == i_cfg.sync_first);
                end
                PH_LEN0: begin
                    n_len_first = i_rx_byte;
                end
                PH_LEN1: begin
                    if (len_short) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_last   = 1'b1;
                        o_res.frame_status = ST_SHORT;
                    end else begin
                        n_body_length      = frame_len - HEADER_BYTES;
                        n_byte_position    = '0;
                        n_running_xor      = '0;
                        n_checksum_matched = 1'b0;
                    end
                end
                PH_BODY: begin
                    if (xor_en) n_running_xor = r_running_xor ^ i_rx_byte;
                    if (sum_point) n_checksum_matched = matched_now;
                    o_res_valid      = 1'b1;
                    o_res.body_byte  = i_rx_byte;
                    o_res.body_index = r_byte_position;
                    if (body_last) begin
                        o_res.frame_last = 1'b1;
                        if (!matched_now) begin
                            o_res.frame_status = ST_SUM;
                        end else if (i_rx_byte != i_cfg.end_marker) begin
                            o_res.frame_status = ST_END;
                        end
                        n_sync_armed = 1'b0;
                    end
                    n_byte_position = r_byte_position + 16'd1;
                end
                default: n_sync_armed = r_sync_armed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HUNT;
            r_sync_armed       <= 1'b0;
            r_len_first        <= '0;
            r_body_length      <= '0;
            r_byte_position    <= '0;
            r_running_xor      <= '0;
            r_checksum_matched <= 1'b0;
        end else begin
            r_phase            <= n_phase;
            r_sync_armed       <= n_sync_armed;
            r_len_first        <= n_len_first;
            r_body_length      <= n_body_length;
            r_byte_position    <= n_byte_position;
            r_running_xor      <= n_running_xor;
            r_checksum_matched <= n_checksum_matched;
        end
    end

endmodule

[sv/sld_out_buf.sv]
// Result register with one skid entry between the framer and the output channel.
// Depends on sld_pkg.
module sld_out_buf
    import sld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_take;

    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // no new result can arrive while the skid entry is held
            if (out_take) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            n_out       = i_res;
            n_out_valid = i_res_valid;
        end else if (i_res_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[sv/sync_length_xor_frame_deframer.sv]
// Sync, length and XOR-checksum frame deframer, top level.
// Depends on sld_pkg, sld_cfg_regs, sld_core and sld_out_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_rx_byte): one received byte per
//   transfer. The framer hunts for sync_first then sync_second, takes two
//   length bytes, then passes out length-4 body bytes.
//   Output channel (o_out_valid / i_out_stall): at most one result per input
//   byte: body byte, its index in the body, a last flag and the frame status
//   (ok, length short, checksum bad, end marker bad; checksum wins).
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): register index
//   and data; unmapped indexes are dropped. Write only while idle.
// Timing:
//   A byte is handled in the cycle it is accepted; its result is registered in
//   the output register, or in the skid entry while the output register is
//   held. Throughput is one byte per cycle while o_in_stall is low.
// Stalls:
//   A result register plus one skid entry separate the two sides. With the
//   skid entry full, o_in_stall rises and no byte is taken until the receiver
//   frees the output register.
// Reset (synchronous, active low): registers return to their defaults, the
//   framer hunts for sync with the match disarmed and both buffers empty.
module sync_length_xor_frame_deframer
    import sld_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // received bytes
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // results
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_body_byte,
    output logic [15:0]        o_body_index,
    output logic               o_frame_last,
    output logic [1:0]         o_frame_status,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    t_result out;
    logic    res_valid;
    logic    buf_full;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign in_accept   = i_in_valid && !buf_full;

    sld_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sld_out_buf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out)
    );

    assign o_body_byte    = out.body_byte;
    assign o_body_index   = out.body_index;
    assign o_frame_last   = out.frame_last;
    assign o_frame_status = out.frame_status;

endmodule

[tb/sync_length_xor_frame_deframer_test.sv]
// Self-checking testbench for sync_length_xor_frame_deframer.
// Needs sld_pkg and the deframer RTL. Sends framed byte streams under several settings
// and checks every result transfer against a frame predictor kept in this bench.
module sync_length_xor_frame_deframer_test;
    import sld_pkg::*;

    // Longest run of cycles with no transfer on any channel before the run is abandoned
    localparam int QuietLimit = 2000;

    // ------------------------------------------------------------------
    // Block ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_body_byte;
    logic [15:0]        o_body_index;
    logic               o_frame_last;
    logic [1:0]         o_frame_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = CFG_SYNC_FIRST;
    logic [15:0]        i_cfg_data = 16'h0000;

    sync_length_xor_frame_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_body_byte    (o_body_byte),
        .o_body_index   (o_body_index),
        .o_frame_last   (o_frame_last),
        .o_frame_status (o_frame_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame predictor: shadow registers and framer state, updated once per
    // accepted byte transfer.
    // ------------------------------------------------------------------
    t_cfg        shadow_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, END_MARKER_RST,
                                MIN_LENGTH_RST, MSB_FIRST_RST};
    t_phase      ph = PH_HUNT;
    logic        hunt_armed = 1'b0;
    logic [7:0]  len_head = 8'h00;
    logic [15:0] body_len = 16'h0000;
    logic [15:0] body_pos = 16'h0000;
    logic [7:0]  sum_acc = 8'h00;
    logic        sum_ok = 1'b0;

    t_result awaited_results[$];   // results owed by the block, oldest first

    int  mismatch_count = 0;
    int  framed_bytes = 0;         // accepted bytes that the framer did not just hunt over
    int  idle_pct = 0;             // sender gap rate, percent
    int  stall_pct = 0;            // receiver stall rate, percent
    int  hold_cycles = 0;          // long receiver hold-off, counted down by the stall driver
    int  len_span = 24;            // spread of accepted frame lengths above the floor
    bit  long_mode = 1'b0;         // floor at its top: only a full 0xFFFF frame is accepted
    int  quiet = 0;

    // Lengths below ten are treated as ten
    function automatic int floor_len();
        return (shadow_cfg.min_frame_length < HARD_MIN_LENGTH) ? int'(HARD_MIN_LENGTH)
                                                               : int'(shadow_cfg.min_frame_length);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, output bit got, output t_result r);
        logic [15:0] total;
        int          p;
        int          l;
        got = 1'b0;
        r = '0;
        case (ph)
            PH_HUNT: begin
                if (hunt_armed && b == shadow_cfg.sync_second) begin
                    hunt_armed = 1'b0;
                    ph = PH_LEN0;
                end else begin
                    hunt_armed = (b == shadow_cfg.sync_first);
                end
            end
            PH_LEN0: begin
                len_head = b;
                ph = PH_LEN1;
            end
            PH_LEN1: begin
                total = shadow_cfg.length_msb_first ? {len_head, b} : {b, len_head};
                if (int'(total) < floor_len()) begin
                    ph = PH_HUNT;
                    got = 1'b1;
                    r = '{8'h00, 16'h0000, 1'b1, ST_SHORT};
                end else begin
                    body_len = total - HEADER_BYTES;
                    body_pos = 16'h0000;
                    sum_acc = 8'h00;
                    sum_ok = 1'b0;
                    ph = PH_BODY;
                end
            end
            default: begin
                p = int'(body_pos);
                l = int'(body_len);
                if (p >= int'(XOR_START) && p + 3 <= l) sum_acc = sum_acc ^ b;
                if (p + 2 == l) sum_ok = (sum_acc == b);
                got = 1'b1;
                r = '{b, body_pos, 1'b0, ST_OK};
                if (p + 1 >= l) begin
                    // last body byte: checksum verdict beats the end marker
                    r.frame_last = 1'b1;
                    if (!sum_ok) r.frame_status = ST_SUM;
                    else if (b != shadow_cfg.end_marker) r.frame_status = ST_END;
                    ph = PH_HUNT;
                    hunt_armed = 1'b0;
                end
                body_pos = body_pos + 16'd1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte sender. Called and returns on a falling edge; valid stays high
    // into the next call so back-to-back transfers need no gap.
    // A typed expectation, where given, replaces the predicted result.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result want = '0);
        bit      got;
        t_result res;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (ph != PH_HUNT) framed_bytes++;
        deframe_byte(b, got, res);
        if (typed) awaited_results.push_back(want);
        else if (got) awaited_results.push_back(res);
        @(negedge i_clk);
    endtask

    // Random byte; a stray length is kept small (and never 0xFFFF) so that an
    // accidental sync cannot swallow the run in one enormous body.
    function automatic logic [7:0] noise_byte();
        logic [7:0] r;
        r = 8'($urandom);
        if ((ph == PH_LEN0 && shadow_cfg.length_msb_first) ||
            (ph == PH_LEN1 && !shadow_cfg.length_msb_first)) r = 8'h00;
        if (ph == PH_LEN1) r[0] = 1'b0;
        return r;
    endfunction

    // Finish whatever the framer is in and leave it hunting, disarmed
    task automatic settle_to_hunt();
        logic [7:0] r;
        while (ph != PH_HUNT || hunt_armed) begin
            if (ph == PH_HUNT) begin
                r = 8'($urandom);
                while (r == shadow_cfg.sync_first || r == shadow_cfg.sync_second)
                    r = 8'($urandom);
                send_byte(r);
            end else begin
                send_byte(noise_byte());
            end
        end
    endtask

    // One frame: sync pair, length, body with checksum and end marker, each
    // occasionally wrong. forced_total < 0 picks a length; cut_short drops the tail.
    task automatic send_frame(input int forced_total, input bit cut_short);
        int          total;
        int          body;
        int          n_bytes;
        int          cut;
        int          floor_l;
        logic [15:0] tot16;
        logic [7:0]  hdr[4];
        logic [7:0]  b;
        logic [7:0]  x;
        settle_to_hunt();
        floor_l = floor_len();
        if (forced_total >= 0) total = forced_total;
        else if (long_mode) total = $urandom_range(65534, 0);
        else if ($urandom_range(9) == 0) total = $urandom_range(floor_l - 1, 0);
        else total = floor_l + $urandom_range(len_span, 0);
        tot16 = 16'(total);
        body = (total >= floor_l) ? total - int'(HEADER_BYTES) : 0;
        hdr[0] = shadow_cfg.sync_first;
        hdr[1] = shadow_cfg.sync_second;
        hdr[2] = shadow_cfg.length_msb_first ? tot16[15:8] : tot16[7:0];
        hdr[3] = shadow_cfg.length_msb_first ? tot16[7:0] : tot16[15:8];
        n_bytes = 4 + body;
        cut = cut_short ? $urandom_range(n_bytes - 1, 1) : n_bytes;
        for (int k = 0; k < 4 && k < cut; k++) send_byte(hdr[k]);
        x = 8'h00;
        for (int i = 0; i < body && 4 + i < cut; i++) begin
            if (i == body - 2)
                b = ($urandom_range(7) == 0) ? x ^ 8'($urandom_range(255, 1)) : x;
            else if (i == body - 1)
                b = ($urandom_range(7) == 0) ? shadow_cfg.end_marker ^ 8'($urandom_range(255, 1))
                                             : shadow_cfg.end_marker;
            else
                b = 8'($urandom);
            if (i >= int'(XOR_START) && i + 3 <= body) x = x ^ b;
            send_byte(b);
        end
    endtask

    // Mostly well-formed frames; the rest truncated frames, noise and lone sync bytes
    task automatic run_random(input int goal);
        int start;
        int pick;
        int n;
        start = framed_bytes;
        while (framed_bytes - start < goal) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_frame(-1, 1'b0);
            end else if (pick < 75) begin
                send_frame(-1, 1'b1);
            end else if (pick < 90) begin
                n = $urandom_range(8, 1);
                repeat (n) send_byte(noise_byte());
            end else begin
                settle_to_hunt();
                send_byte(shadow_cfg.sync_first);
                send_byte(noise_byte());
            end
        end
    endtask

    // Sender quiet until every owed result has been taken
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write on the config channel; the shadow copy follows on the transfer
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SYNC_FIRST:  shadow_cfg.sync_first = data[7:0];
            CFG_SYNC_SECOND: shadow_cfg.sync_second = data[7:0];
            CFG_END_MARKER:  shadow_cfg.end_marker = data[7:0];
            CFG_MIN_LENGTH:  shadow_cfg.min_frame_length = data;
            CFG_MSB_FIRST:   shadow_cfg.length_msb_first = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // All five registers; unused upper data bits carry junk that must be dropped
    task automatic configure(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] em,
                             input logic [15:0] minl, input logic msb);
        write_reg(CFG_SYNC_FIRST, {8'($urandom), sf});
        write_reg(CFG_SYNC_SECOND, {8'($urandom), ss});
        write_reg(CFG_END_MARKER, {8'($urandom), em});
        write_reg(CFG_MIN_LENGTH, minl);
        write_reg(CFG_MSB_FIRST, {15'($urandom), msb});
    endtask

    // ------------------------------------------------------------------
    // Directed opening, reset settings (sync E1 1E, end EF, minimum 10, MSB first):
    // hunting with a repeated first sync byte, a length one short of the minimum,
    // a minimum-length frame with no checksummed bytes, and a frame where both
    // the checksum and the end marker are wrong.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam int DirRows = 27;

    t_dir_row dir_rows [DirRows] = '{
        '{8'h00, 1'b0, '0},                                   // hunting, not armed
        '{8'hE1, 1'b0, '0},                                   // arms
        '{8'hE1, 1'b0, '0},                                   // stays armed
        '{8'h1E, 1'b0, '0},                                   // sync complete
        '{8'h00, 1'b0, '0},
        '{8'h09, 1'b1, '{8'h00, 16'd0, 1'b1, ST_SHORT}},      // length 9: too short
        '{8'hE1, 1'b0, '0},
        '{8'h1E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h0A, 1'b0, '0},                                   // length 10, six body bytes
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h00, 1'b0, '0},                                   // checksum of nothing
        '{8'hEF, 1'b1, '{8'hEF, 16'd5, 1'b1, ST_OK}},
        '{8'hE1, 1'b0, '0},
        '{8'h1E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h0B, 1'b0, '0},                                   // length 11, one summed byte
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h3C, 1'b0, '0},
        '{8'h3D, 1'b0, '0},                                   // checksum wrong
        '{8'h00, 1'b1, '{8'h00, 16'd6, 1'b1, ST_SUM}}         // end wrong too: checksum wins
    };

    // ------------------------------------------------------------------
    // Receiver: stall pattern driven on the falling edge. A requested
    // hold-off is counted down here, one cycle at a time.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Result transfers are compared field by field with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result transfer: byte %0h index %0d", o_body_byte,
                       o_body_index);
                mismatch_count++;
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_body_byte !== exp_r.body_byte) begin
                    $error("body_byte: expected %0h, got %0h", exp_r.body_byte, o_body_byte);
                    mismatch_count++;
                end
                if (o_body_index !== exp_r.body_index) begin
                    $error("body_index: expected %0d, got %0d", exp_r.body_index,
                           o_body_index);
                    mismatch_count++;
                end
                if (o_frame_last !== exp_r.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", exp_r.frame_last,
                           o_frame_last);
                    mismatch_count++;
                end
                if (o_frame_status !== exp_r.frame_status) begin
                    $error("frame_status: expected %0d, got %0d", exp_r.frame_status,
                           o_frame_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transfer on any channel means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QuietLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence. Registers change only with nothing owed and the sender
    // quiet.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, no gaps: directed rows, then a long receiver hold-off
        // while bytes keep coming so the block backs up and stalls its input.
        foreach (dir_rows[k]) send_byte(dir_rows[k].rx, dir_rows[k].typed, dir_rows[k].want);
        hold_cycles = 150;
        run_random(200);
        drain_results();

        // Sync 00/FF, end 00, minimum 0 (acts as 10), LSB first; sender gaps
        configure(8'h00, 8'hFF, 8'h00, 16'h0000, 1'b0);
        idle_pct = 52;
        run_random(230);
        drain_results();

        // Sync FF/00, end FF, minimum 9, MSB first; receiver stalls, and the
        // sender pauses midway until every result is home
        configure(8'hFF, 8'h00, 8'hFF, 16'd9, 1'b1);
        idle_pct = 0;
        stall_pct = 52;
        run_random(115);
        drain_results();
        run_random(115);
        drain_results();

        // Random settings, a write to an unmapped index, gaps on both sides
        configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(40, 11)),
                  1'($urandom));
        write_reg(CFG_MSB_FIRST + 3'($urandom_range(3, 1)), 16'($urandom));
        idle_pct = 23;
        stall_pct = 23;
        run_random(230);
        drain_results();

        // Minimum at its top: every length below 0xFFFF is reported short
        configure(8'hE1, 8'h1E, 8'hEF, 16'hFFFF, 1'b1);
        idle_pct = 0;
        stall_pct = 0;
        long_mode = 1'b1;
        run_random(100);
        drain_results();
        long_mode = 1'b0;

        // Both sync bytes equal: an armed repeat completes the sync
        configure(8'h5A, 8'h5A, 8'hEF, 16'd10, 1'b1);
        idle_pct = 23;
        stall_pct = 23;
        run_random(230);
        drain_results();

        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
